/* src/dct_zero_run_histogram_top_defines.svh */
// Assertion macros used by the port checker in src/dzrh_checker.sv.
// Needs signals clk and rst_n in the scope of each use.
`ifndef DCT_ZERO_RUN_HISTOGRAM_TOP_DEFINES_SVH
`define DCT_ZERO_RUN_HISTOGRAM_TOP_DEFINES_SVH

// same-cycle implication
`define DZRH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DZRH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dzrh_pkg.sv */
// Types, codes and default sizes for the zero-run histogram block.
// No dependencies.
package dzrh_pkg;

    localparam int DEF_MAX_RUN = 64;
    localparam int DEF_MIN_VAL = -256;
    localparam int DEF_MAX_VAL = 255;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // bump slots, lowest served first
    localparam int BUMP_RUN    = 0;
    localparam int BUMP_PREFIX = 1;
    localparam int BUMP_VALUE  = 2;
    localparam int BUMP_EOB    = 3;
    localparam int NUM_BUMPS   = 4;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] coefficient;
        logic               first_of_block;
        logic               last_of_block;
        logic [9:0]         bin_index;
    } req_word_t;

    typedef struct packed {
        logic [31:0] bin_count;
        logic [9:0]  bin_echo;
    } rsp_word_t;

    typedef struct packed {
        logic ld_item;
        logic bump_rd;
        logic bump_wr;
        logic bin_rd;
        logic out_load;
        logic clr_step;
    } dp_cmd_t;

    typedef struct packed {
        logic pend_any;
        logic clr_last;
        logic out_busy;
    } dp_sts_t;

endpackage

/* src/dzrh_datapath.sv */
// Datapath: histogram memory, zero-run state, bump queue, sweep counter, output word.
// Depends on dzrh_pkg; driven by dzrh_ctrl.
module dzrh_datapath
    import dzrh_pkg::*;
#(
    parameter int MAX_RUN = DEF_MAX_RUN,
    parameter int MIN_VAL = DEF_MIN_VAL,
    parameter int MAX_VAL = DEF_MAX_VAL
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_word_t req,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts,
    input  logic      rsp_ready,
    output logic      rsp_valid,
    output rsp_word_t rsp
);

    localparam int NBINS  = MAX_RUN + MAX_VAL - MIN_VAL + 3;
    localparam int VBASE  = MAX_RUN + 1 - MIN_VAL;
    localparam int ADDR_W = $clog2(NBINS);
    localparam int RUN_W  = $clog2(MAX_RUN + 1);

    localparam logic signed [15:0] MIN_C     = 16'(MIN_VAL);
    localparam logic signed [15:0] MAX_C     = 16'(MAX_VAL);
    localparam logic [RUN_W-1:0]   RUN_MAX_C = RUN_W'(MAX_RUN);
    localparam logic [ADDR_W-1:0]  PREFIX_A  = ADDR_W'(VBASE);
    localparam logic [ADDR_W-1:0]  EOB_A     = ADDR_W'(VBASE + MAX_VAL + 1);
    localparam logic [ADDR_W-1:0]  LAST_A    = ADDR_W'(NBINS - 1);

    logic [31:0] mem [0:NBINS-1];
    logic [31:0] rd_data_reg;

    req_word_t   item_reg;
    logic        in_run_reg, in_run_next;
    logic [RUN_W-1:0] run_len_reg, run_len_next;
    logic [NUM_BUMPS-1:0] pend_reg, pend_next;
    logic [ADDR_W-1:0] bump_addr_reg [NUM_BUMPS];
    logic [ADDR_W-1:0] bump_addr_next [NUM_BUMPS];
    logic [ADDR_W-1:0] cur_addr_reg;
    logic [1:0]        cur_sel_reg;
    logic [ADDR_W-1:0] clr_idx_reg;
    logic              out_valid_reg;
    rsp_word_t         out_reg;

    logic signed [15:0] val_c;
    logic               in_eff, in_mid;
    logic [RUN_W-1:0]   rl_eff, rl_mid;
    logic [1:0]         sel;
    logic               we, re;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [31:0]        wdata, inc_data;
    logic               bin_in_range;

    // plan of one coefficient
    always_comb
    begin
        if (req.coefficient < MIN_C)
            val_c = MIN_C;
        else if (req.coefficient > MAX_C)
            val_c = MAX_C;
        else
            val_c = req.coefficient;

        in_eff = req.first_of_block ? 1'b1 : in_run_reg;
        rl_eff = req.first_of_block ? '0 : run_len_reg;

        pend_next = '0;
        if (val_c != 16'sd0)
        begin
            pend_next[BUMP_RUN]    = in_eff && (rl_eff != '0);
            pend_next[BUMP_PREFIX] = in_eff && (rl_eff != '0);
            pend_next[BUMP_VALUE]  = 1'b1;
            in_mid = 1'b0;
            rl_mid = '0;
        end
        else if (in_eff)
        begin
            in_mid = 1'b1;
            rl_mid = (rl_eff == RUN_MAX_C) ? rl_eff : rl_eff + RUN_W'(1);
        end
        else
        begin
            in_mid = 1'b1;
            rl_mid = RUN_W'(1);
        end

        if (req.last_of_block)
        begin
            pend_next[BUMP_EOB] = in_mid && (rl_mid != '0);
            in_run_next  = 1'b1;
            run_len_next = '0;
        end
        else
        begin
            in_run_next  = in_mid;
            run_len_next = rl_mid;
        end

        bump_addr_next[BUMP_RUN]    = ADDR_W'(rl_eff);
        bump_addr_next[BUMP_PREFIX] = PREFIX_A;
        bump_addr_next[BUMP_VALUE]  = ADDR_W'(VBASE + int'(val_c));
        bump_addr_next[BUMP_EOB]    = EOB_A;
    end

    always_comb
    begin
        sel = 2'd0;
        for (int i = NUM_BUMPS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
                sel = 2'(i);
        end
    end

    assign inc_data     = (rd_data_reg == 32'hFFFF_FFFF) ? rd_data_reg : rd_data_reg + 32'd1;
    assign bin_in_range = 32'(item_reg.bin_index) < NBINS;

    assign we    = cmd.bump_wr || cmd.clr_step;
    assign waddr = cmd.clr_step ? clr_idx_reg : cur_addr_reg;
    assign wdata = cmd.clr_step ? 32'd0 : inc_data;
    assign re    = cmd.bump_rd || cmd.bin_rd;
    assign raddr = cmd.bin_rd ? ADDR_W'(item_reg.bin_index) : bump_addr_reg[sel];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg    <= 1'b1;
            run_len_reg   <= '0;
            pend_reg      <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ld_item && (req.func == FUNC_ADD))
            begin
                in_run_reg  <= in_run_next;
                run_len_reg <= run_len_next;
                pend_reg    <= pend_next;
            end
            else if (cmd.bump_wr)
                pend_reg[cur_sel_reg] <= 1'b0;

            if (cmd.clr_step)
                clr_idx_reg <= (clr_idx_reg == LAST_A) ? '0 : clr_idx_reg + ADDR_W'(1);

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            item_reg <= req;
            for (int i = 0; i < NUM_BUMPS; i++)
                bump_addr_reg[i] <= bump_addr_next[i];
        end
        if (cmd.bump_rd)
        begin
            cur_addr_reg <= bump_addr_reg[sel];
            cur_sel_reg  <= sel;
        end
        if (cmd.out_load)
        begin
            out_reg.bin_count <= bin_in_range ? rd_data_reg : 32'd0;
            out_reg.bin_echo  <= item_reg.bin_index;
        end
    end

    assign sts.pend_any = |pend_reg;
    assign sts.clr_last = clr_idx_reg == LAST_A;
    assign sts.out_busy = out_valid_reg && !rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

/* src/dzrh_ctrl.sv */
// Controller: sequences accept, bin updates, bin reads and the clearing sweep.
// Depends on dzrh_pkg; commands dzrh_datapath.
module dzrh_ctrl
    import dzrh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_func,
    output logic       req_ready,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_BRD   = 6'b000100,
        S_BWR   = 6'b001000,
        S_RDQ   = 6'b010000,
        S_RDD   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.ld_item = 1'b1;
                    case (req_func)
                        FUNC_ADD:   state_next = S_BRD;
                        FUNC_READ:  state_next = S_RDQ;
                        FUNC_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_BRD:
            begin
                if (sts.pend_any)
                begin
                    cmd.bump_rd = 1'b1;
                    state_next  = S_BWR;
                end
                else
                    state_next = S_IDLE;
            end
            S_BWR:
            begin
                cmd.bump_wr = 1'b1;
                state_next  = S_BRD;
            end
            S_RDQ:
            begin
                cmd.bin_rd = 1'b1;
                state_next = S_RDD;
            end
            S_RDD:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

/* src/dct_zero_run_histogram_top.sv */
// Top level of the zero-run histogram block: controller plus datapath.
// Depends on dzrh_pkg, dzrh_ctrl, dzrh_datapath.
//
// Use: words enter on req (valid/ready). func ADD feeds one clamped AC
// coefficient in scan order, func READ asks for one bin, func CLEAR zeroes
// every bin; code 3 is dropped. Only READ gives a word on rsp (valid/ready):
// the bin count (0 beyond the table) and the echoed index.
// Sequencing: one word is handled at a time. An ADD does each bin update as a
// read then a write of the bin (S_BRD, S_BWR), one update after another.
// A READ reads the bin (S_RDQ) and loads the answer (S_RDD); req_ready returns with
// the answer. A CLEAR holds req_ready low while it zeroes all NBINS bins (578 by default).
// Reset: the zero-run state restarts and a sweep over all NBINS bins zeroes the
// memory; req_ready stays low until it finishes.
// Stall: a READ answer waits in the output register while rsp_ready is low,
// and the next word is taken meanwhile; a further READ holds until the
// register is free.
module dct_zero_run_histogram_top
    import dzrh_pkg::*;
#(
    parameter int MAX_RUN = DEF_MAX_RUN,
    parameter int MIN_VAL = DEF_MIN_VAL,
    parameter int MAX_VAL = DEF_MAX_VAL
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    dzrh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_func  (req.func),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dzrh_datapath #(
        .MAX_RUN (MAX_RUN),
        .MIN_VAL (MIN_VAL),
        .MAX_VAL (MAX_VAL)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

/* src/dzrh_checker.sv */
// Port-level checks for the zero-run histogram block, bound to the top level.
// Depends on dzrh_pkg and dct_zero_run_histogram_top_defines.svh.
`include "dct_zero_run_histogram_top_defines.svh"

module dzrh_port_checks
    import dzrh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input req_word_t req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_word_t rsp
);

    `DZRH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
    `DZRH_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp), "rsp word changed while stalled")
    `DZRH_ASSERT_NEXT(a_busy_after_op, req_valid && req_ready && (req.func == FUNC_ADD || req.func == FUNC_READ || req.func == FUNC_CLEAR), !req_ready, "ready held after an operation")
    `DZRH_ASSERT_SAME(a_rsp_after_busy, $rose(rsp_valid), $past(!req_ready), "answer without busy read phase")

endmodule

bind dct_zero_run_histogram_top dzrh_port_checks u_dzrh_checker (.*);

/* sim/dzrh_checker.sv */
// Checker for the zero-run histogram block: watches both channels, keeps its own
// copy of the bins and run state, and compares every read answer.
// Depends on dzrh_pkg.
module dzrh_checker
    import dzrh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  req_word_t req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsp_word_t rsp,
    output int        mismatch_count,
    output int        reads_waiting
);

    localparam int NUM_BINS   = DEF_MAX_RUN + DEF_MAX_VAL - DEF_MIN_VAL + 3;
    localparam int VAL_BASE   = DEF_MAX_RUN + 1 - DEF_MIN_VAL;
    localparam int PREFIX_BIN = VAL_BASE;
    localparam int EOB_BIN    = VAL_BASE + DEF_MAX_VAL + 1;

    logic [31:0] hist_bins [NUM_BINS];
    logic        zrun_open;
    logic [6:0]  zrun_len;
    rsp_word_t   expected_reads [$];
    rsp_word_t   want;
    int          fails;

    function automatic void bump_bin(input int idx);
        if (idx >= 0 && idx < NUM_BINS && hist_bins[idx] != 32'hFFFF_FFFF)
        begin
            hist_bins[idx]++;
        end
    endfunction

    function automatic void clear_bins();
        for (int i = 0; i < NUM_BINS; i++)
        begin
            hist_bins[i] = '0;
        end
    endfunction

    function automatic void apply_word(input req_word_t w);
        rsp_word_t ans;
        int        v;
        case (w.func)
            FUNC_READ:
            begin
                ans.bin_count = (w.bin_index < NUM_BINS) ? hist_bins[w.bin_index] : '0;
                ans.bin_echo  = w.bin_index;
                expected_reads.push_back(ans);
            end
            FUNC_CLEAR:
            begin
                clear_bins();
            end
            FUNC_ADD:
            begin
                v = int'(w.coefficient);
                if (v < DEF_MIN_VAL)
                begin
                    v = DEF_MIN_VAL;
                end
                if (v > DEF_MAX_VAL)
                begin
                    v = DEF_MAX_VAL;
                end
                if (w.first_of_block)
                begin
                    zrun_open = 1'b1;
                    zrun_len  = '0;
                end
                if (v != 0)
                begin
                    if (zrun_open && zrun_len != 0)
                    begin
                        bump_bin(int'(zrun_len));
                        bump_bin(PREFIX_BIN);
                    end
                    zrun_open = 1'b0;
                    zrun_len  = '0;
                    bump_bin(VAL_BASE + v);
                end
                else if (zrun_open)
                begin
                    if (zrun_len < DEF_MAX_RUN)
                    begin
                        zrun_len++;
                    end
                end
                else
                begin
                    zrun_open = 1'b1;
                    zrun_len  = 7'd1;
                end
                if (w.last_of_block)
                begin
                    if (zrun_open && zrun_len != 0)
                    begin
                        bump_bin(EOB_BIN);
                    end
                    zrun_open = 1'b1;
                    zrun_len  = '0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_bins();
            zrun_open = 1'b1;
            zrun_len  = '0;
            expected_reads.delete();
            fails = 0;
            mismatch_count <= 0;
            reads_waiting  <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    $error("unexpected read answer, bin_echo %0d", rsp.bin_echo);
                    fails++;
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (rsp.bin_count !== want.bin_count)
                    begin
                        $error("bin_count: expected %0d, got %0d", want.bin_count,
                               rsp.bin_count);
                        fails++;
                    end
                    if (rsp.bin_echo !== want.bin_echo)
                    begin
                        $error("bin_echo: expected %0d, got %0d", want.bin_echo,
                               rsp.bin_echo);
                        fails++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                apply_word(req);
            end
            mismatch_count <= fails;
            reads_waiting  <= expected_reads.size();
        end
    end

endmodule

/* sim/tb.sv */
// Testbench top for the zero-run histogram block: clock, reset, word stimulus
// with random idling and back-pressure, and the verdict.
// Depends on dzrh_pkg, dct_zero_run_histogram_top and dzrh_checker.
module tb;
    import dzrh_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int NUM_BINS   = DEF_MAX_RUN + DEF_MAX_VAL - DEF_MIN_VAL + 3;
    localparam int VAL_BASE   = DEF_MAX_RUN + 1 - DEF_MIN_VAL;
    localparam int PREFIX_BIN = VAL_BASE;
    localparam int EOB_BIN    = VAL_BASE + DEF_MAX_VAL + 1;
    localparam int WORD_TARGET = 700;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_word_t rsp;
    logic      steady;
    logic      hold_rsp;
    int        mismatch_count;
    int        reads_waiting;
    int        words_sent;

    dct_zero_run_histogram_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    dzrh_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .reads_waiting  (reads_waiting)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("tb: done, errors");
        $finish;
    end

    // answer side: random idling, one long hold-off on request
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                rsp_ready <= steady || ($urandom_range(99) >= 13);
            end
        end
    end

    function automatic req_word_t make_word(input logic [1:0] f, input int coef,
                                            input bit first, input bit last,
                                            input int idx);
        req_word_t w;
        w.func           = f;
        w.coefficient    = coef[15:0];
        w.first_of_block = first;
        w.last_of_block  = last;
        w.bin_index      = idx[9:0];
        return w;
    endfunction

    function automatic int pick_coef();
        int         k;
        logic [15:0] raw;
        k = $urandom_range(99);
        raw = 16'($urandom);
        if (k < 50)
        begin
            return 0;
        end
        if (k < 80)
        begin
            return $urandom_range(1) ? $urandom_range(1, 15) : -$urandom_range(1, 15);
        end
        if (k < 90)
        begin
            return $urandom_range(1) ? $urandom_range(16, 300) : -$urandom_range(16, 300);
        end
        return int'($signed(raw));
    endfunction

    function automatic int pick_bin();
        int k;
        k = $urandom_range(99);
        if (k < 40)
        begin
            return $urandom_range(DEF_MAX_RUN);
        end
        if (k < 80)
        begin
            return $urandom_range(DEF_MAX_RUN + 1, NUM_BINS - 1);
        end
        if (k < 90)
        begin
            return $urandom_range(NUM_BINS, 1023);
        end
        return $urandom_range(1023);
    endfunction

    task automatic send_word(input req_word_t w);
        if (!steady && $urandom_range(99) < 13)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        if (w.func != FUNC_UNUSED)
        begin
            words_sent++;
        end
    endtask

    task automatic send_read();
        send_word(make_word(FUNC_READ, $urandom, 1'($urandom_range(1)),
                            1'($urandom_range(1)), pick_bin()));
    endtask

    task automatic wait_answers();
        req_valid <= 1'b0;
        @(posedge clk);
        while (reads_waiting != 0)
        begin
            @(posedge clk);
        end
    endtask

    // one transform block of coefficients, sometimes with broken framing
    task automatic send_block();
        int len;
        int k;
        int coef;
        bit long_zeros;
        bit open_first;
        bit close_last;
        k = $urandom_range(99);
        long_zeros = (k < 10);
        if (long_zeros)
        begin
            len = $urandom_range(60, 80);
        end
        else if (k < 85)
        begin
            len = $urandom_range(1, 16);
        end
        else
        begin
            len = $urandom_range(17, 63);
        end
        open_first = ($urandom_range(99) >= 10);
        close_last = ($urandom_range(99) >= 10);
        for (int i = 0; i < len; i++)
        begin
            if (long_zeros)
            begin
                coef = (i == len - 1 && $urandom_range(1)) ? pick_coef() : 0;
            end
            else
            begin
                coef = pick_coef();
            end
            send_word(make_word(FUNC_ADD, coef, open_first && i == 0,
                                close_last && i == len - 1, $urandom));
            if ($urandom_range(99) < 15)
            begin
                send_read();
            end
        end
    endtask

    initial
    begin
        logic [$bits(req_word_t)-1:0] noise;
        logic [31:0] rnd;
        int k;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        steady     = 1'b0;
        hold_rsp   = 1'b0;
        words_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: framing, clamping, saturation-free corner cases, reads out of range
        send_word(make_word(FUNC_READ, 0, 1, 1, 0));
        send_word(make_word(FUNC_ADD, 0, 1, 0, 0));
        send_word(make_word(FUNC_ADD, 0, 0, 0, 0));
        send_word(make_word(FUNC_ADD, 5, 0, 0, 0));
        send_word(make_word(FUNC_ADD, 0, 0, 0, 0));
        send_word(make_word(FUNC_ADD, -32768, 0, 0, 1023));
        send_word(make_word(FUNC_ADD, 32767, 0, 1, 0));
        send_word(make_word(FUNC_ADD, 0, 1, 0, 0));
        send_word(make_word(FUNC_ADD, 0, 0, 1, 0));
        send_word(make_word(FUNC_ADD, 0, 1, 1, 0));
        send_word(make_word(FUNC_ADD, -1, 1, 1, 0));
        send_word(make_word(FUNC_UNUSED, 3, 1, 1, 5));
        send_word(make_word(FUNC_READ, 0, 0, 0, 1));
        send_word(make_word(FUNC_READ, 0, 0, 0, 2));
        send_word(make_word(FUNC_READ, 0, 0, 0, PREFIX_BIN));
        send_word(make_word(FUNC_READ, 0, 0, 0, VAL_BASE + DEF_MIN_VAL));
        send_word(make_word(FUNC_READ, 0, 0, 0, VAL_BASE + DEF_MAX_VAL));
        send_word(make_word(FUNC_READ, 0, 0, 0, EOB_BIN));
        send_word(make_word(FUNC_READ, 0, 0, 0, 1023));
        send_word(make_word(FUNC_READ, 0, 0, 0, NUM_BINS));
        send_word(make_word(FUNC_ADD, 0, 1, 0, 0));
        send_word(make_word(FUNC_CLEAR, -1, 1, 1, 1023));
        send_word(make_word(FUNC_ADD, 9, 0, 1, 0));
        send_word(make_word(FUNC_READ, 0, 0, 0, 1));
        send_word(make_word(FUNC_READ, 0, 0, 0, EOB_BIN));
        wait_answers();

        // answer side held off while reads pile up
        hold_rsp <= 1'b1;
        send_read();
        hold_rsp <= 1'b0;
        for (int i = 0; i < 30; i++)
        begin
            if ($urandom_range(99) < 70)
            begin
                send_read();
            end
            else
            begin
                send_word(make_word(FUNC_ADD, pick_coef(), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), $urandom));
            end
        end
        wait_answers();

        while (words_sent < WORD_TARGET)
        begin
            steady <= (words_sent >= 300 && words_sent < 420);
            k = $urandom_range(99);
            if (k < 70)
            begin
                send_block();
            end
            else if (k < 85)
            begin
                send_read();
            end
            else if (k < 87)
            begin
                send_word(make_word(FUNC_CLEAR, $urandom, 1'($urandom_range(1)),
                                    1'($urandom_range(1)), $urandom));
            end
            else if (k < 90)
            begin
                send_word(make_word(FUNC_UNUSED, $urandom, 1'($urandom_range(1)),
                                    1'($urandom_range(1)), $urandom));
            end
            else if (k < 98)
            begin
                rnd   = $urandom;
                noise = rnd[$bits(req_word_t)-1:0];
                send_word(noise);
            end
            else
            begin
                wait_answers();
            end
        end

        wait_answers();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
